@@ rtl/tdc_pkg.sv @@
// shared widths, constants and types for the tone timer divisor calculation
package tdc_pkg;

   localparam int unsigned FREQ_W  = 32;
   localparam int unsigned CLK_W   = 32;
   localparam int unsigned FIELD_W = 16;
   localparam int unsigned MULT_W  = FIELD_W + 1;
   localparam int unsigned PROD_W  = FREQ_W + MULT_W;

   localparam logic [CLK_W-1:0]   CLK_RESET   = CLK_W'(48000000);
   localparam logic [FIELD_W-1:0] PERIOD_MAX  = '1;
   // period max plus two: multiplier for the first estimate of the prescaler
   localparam logic [MULT_W-1:0]  PSC_DIVISOR = MULT_W'({1'b0, PERIOD_MAX}) + MULT_W'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1_GO,
      ST_MUL1_WAIT,
      ST_DIV1_GO,
      ST_DIV1_WAIT,
      ST_MUL2_GO,
      ST_MUL2_WAIT,
      ST_DIV2_GO,
      ST_DIV2_WAIT,
      ST_OUT
   } state_type;

endpackage

@@ rtl/tdc_serial_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module tdc_serial_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdc_pkg::FREQ_W-1:0]  mcand,
   input  logic [tdc_pkg::MULT_W-1:0]  mult,
   output logic                        done,
   output logic [tdc_pkg::PROD_W-1:0]  product
);
   import tdc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MULT_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [FREQ_W-1:0]   mcand_ff, mcand_in;
   logic [FREQ_W:0]     sum;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      sum      = {1'b0, prod_ff[PROD_W-1:MULT_W]};
      if (prod_ff[0]) begin
         sum = {1'b0, prod_ff[PROD_W-1:MULT_W]} + {1'b0, mcand_ff};
      end
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(MULT_W - 1);
         prod_in  = {{FREQ_W{1'b0}}, mult};
         mcand_in = mcand;
      end else if (busy_ff) begin
         // high half accumulates, low half shifts out the multiplier bits
         prod_in = {sum, prod_ff[MULT_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

@@ rtl/tdc_serial_div.sv @@
// restoring divider, one quotient bit per cycle
module tdc_serial_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdc_pkg::CLK_W-1:0]   dividend,
   input  logic [tdc_pkg::PROD_W-1:0]  divisor,
   output logic                        done,
   output logic [tdc_pkg::CLK_W-1:0]   quotient
);
   import tdc_pkg::*;

   localparam int unsigned CNT_W = $clog2(CLK_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CLK_W-1:0]    rem_ff, rem_in;
   logic [CLK_W-1:0]    quo_ff, quo_in;
   logic [PROD_W-1:0]   dsr_ff, dsr_in;
   logic [CLK_W:0]      trial;
   logic [CLK_W:0]      diff;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[CLK_W-1]};
      fits    = {{(PROD_W-CLK_W-1){1'b0}}, trial} >= dsr_ff;
      diff    = trial - dsr_ff[CLK_W:0];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(CLK_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out the top as quotient bits shift in
         rem_in = fits ? diff[CLK_W-1:0] : trial[CLK_W-1:0];
         quo_in = {quo_ff[CLK_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/tone_timer_divisor_calc.sv @@
// top level: timer prescaler and period calculation for a requested tone
//
// Each request item carries a tone frequency; the block answers with one item
// holding the smallest 16-bit prescaler for which the timer period fits in
// 16 bits, that period, a 50% compare value and an ok flag. ok is 0 with all
// other fields 0 for a zero frequency or a frequency above the timer clock.
// Items are worked one at a time: the next request is taken only after the
// answer for the last one has been placed at the output. The work is two
// passes through a 17-step serial multiplier and two passes through a 32-step
// serial divider, each begun from its own start state and ended on the unit's
// done pulse. A zero frequency skips these passes and goes straight to the
// output step. A stalled answer holds the sequencer only at its output step.
// A new request is taken while the previous answer still waits at the output.
// The user writes the timer clock register through csr_we/csr_wdata only
// while idle; the block itself does not enforce this.
module tone_timer_divisor_calc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tdc_pkg::CLK_W-1:0]   csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tdc_pkg::FREQ_W-1:0]  req_freq_hz,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [tdc_pkg::FIELD_W-1:0] rsp_prescaler,
   output logic [tdc_pkg::FIELD_W-1:0] rsp_period,
   output logic [tdc_pkg::FIELD_W-1:0] rsp_pulse
);
   import tdc_pkg::*;

   state_type            state_ff, state_in;
   logic [CLK_W-1:0]     clk_hz_ff;
   logic [FREQ_W-1:0]    freq_ff;
   logic                 fzero_ff;
   logic [FIELD_W-1:0]   psc_ff, psc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 ok_ff, ok_in;
   logic [FIELD_W-1:0]   prescaler_ff, prescaler_in;
   logic [FIELD_W-1:0]   period_ff, period_in;
   logic [FIELD_W-1:0]   pulse_ff, pulse_in;

   logic                 accept;
   logic                 out_free;
   logic                 mul_start, mul_done;
   logic [MULT_W-1:0]    mul_op;
   logic [PROD_W-1:0]    mul_prod;
   logic                 div_start, div_done;
   logic [CLK_W-1:0]     div_quo;
   logic [CLK_W-1:0]     q_minus1;
   logic                 q_fits;

   tdc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (freq_ff),
      .mult    (mul_op),
      .done    (mul_done),
      .product (mul_prod)
   );

   tdc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_hz_ff),
      .divisor  (mul_prod),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_freq_hz == '0) ? ST_OUT : ST_MUL1_GO;
            end
         end
         ST_MUL1_GO:   state_in = ST_MUL1_WAIT;
         ST_MUL1_WAIT: if (mul_done) state_in = ST_DIV1_GO;
         ST_DIV1_GO:   state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (div_done) state_in = ST_MUL2_GO;
         ST_MUL2_GO:   state_in = ST_MUL2_WAIT;
         ST_MUL2_WAIT: if (mul_done) state_in = ST_DIV2_GO;
         ST_DIV2_GO:   state_in = ST_DIV2_WAIT;
         ST_DIV2_WAIT: if (div_done) state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_op    = PSC_DIVISOR;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_MUL1_GO: mul_start = 1'b1;
         ST_DIV1_GO: div_start = 1'b1;
         ST_MUL2_GO: begin
            mul_start = 1'b1;
            mul_op    = {1'b0, psc_ff} + MULT_W'(1);
         end
         ST_DIV2_GO: div_start = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // prescaler estimate, clamped to 16 bits
   always_comb begin
      psc_in = psc_ff;
      if (state_ff == ST_DIV1_WAIT && div_done) begin
         psc_in = (div_quo > CLK_W'(PERIOD_MAX)) ? PERIOD_MAX : div_quo[FIELD_W-1:0];
      end
   end

   // result assembly: quotient must be 1 .. period max plus one
   always_comb begin
      q_minus1     = div_quo - CLK_W'(1);
      q_fits       = (div_quo != '0) && (q_minus1 <= CLK_W'(PERIOD_MAX));
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      prescaler_in = prescaler_ff;
      period_in    = period_ff;
      pulse_in     = pulse_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         if (!fzero_ff && q_fits) begin
            ok_in        = 1'b1;
            prescaler_in = psc_ff;
            period_in    = q_minus1[FIELD_W-1:0];
            pulse_in     = div_quo[FIELD_W:1];
         end else begin
            ok_in        = 1'b0;
            prescaler_in = '0;
            period_in    = '0;
            pulse_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clk_hz_ff    <= CLK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            clk_hz_ff <= csr_wdata;
         end
      end
      if (accept) begin
         freq_ff  <= req_freq_hz;
         fzero_ff <= (req_freq_hz == '0);
      end
      psc_ff       <= psc_in;
      ok_ff        <= ok_in;
      prescaler_ff <= prescaler_in;
      period_ff    <= period_in;
      pulse_ff     <= pulse_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_prescaler = prescaler_ff;
   assign rsp_period    = period_ff;
   assign rsp_pulse     = pulse_ff;

endmodule
